>>> src/bpc_pkg.sv
// shared types and constants of the button press classifier
package bpc_pkg;

  // configuration register indexes
  localparam logic [7:0] CfgDebounceTicks  = 8'd0;
  localparam logic [7:0] CfgLongPressTicks = 8'd1;

  // register reset values
  localparam logic [15:0] DebounceTicksReset  = 16'd10;
  localparam logic [15:0] LongPressTicksReset = 16'd1000;

  typedef enum logic [1:0] {
    EvIdle  = 2'd0,
    EvShort = 2'd1,
    EvLong  = 2'd2
  } press_event_e;

  typedef struct packed {
    logic pin_level;
    logic read_clear;
  } in_word_t;

  typedef struct packed {
    logic [1:0] press_event;
    logic       long_timer_running;
  } out_word_t;

endpackage

>>> src/button_press_classifier_top.sv
// top level of the debounced short/long button press classifier
//
// channel | direction | handshake                   | word
// --------+-----------+-----------------------------+-------------------------------
// in      | input     | in_valid_i / in_ready_o     | in_word_i (pin_level, read_clear)
// out     | output    | out_valid_o / out_ready_i   | out_word_o (press_event, timer)
// cfg     | input     | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
// one tick word is taken per cycle while in_ready_o is high; its result is registered
// the core state advances in the cycle of acceptance and the result is parked
// in a two-entry output buffer, so input keeps flowing while a result waits
// in_ready_o drops only when both buffer entries hold untaken results
// reset clears all state, the buffer and restores the default tick counts
// cfg writes are always taken and act at the next counter load
module button_press_classifier_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bpc_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bpc_pkg::out_word_t out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import bpc_pkg::*;

  logic [15:0] debounce_ticks_q;
  logic [15:0] long_press_ticks_q;
  logic        step;
  logic        space;
  out_word_t   res_word;

  // configuration registers, unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q   <= DebounceTicksReset;
      long_press_ticks_q <= LongPressTicksReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgDebounceTicks) begin
        debounce_ticks_q <= cfg_data_i;
      end else if (cfg_index_i == CfgLongPressTicks) begin
        long_press_ticks_q <= cfg_data_i;
      end
    end
  end

  // a tick advances the core only when its result has a buffer slot
  assign in_ready_o = space;
  assign step       = in_valid_i && space;

  bpc_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .in_word_i          (in_word_i),
    .debounce_ticks_i   (debounce_ticks_q),
    .long_press_ticks_i (long_press_ticks_q),
    .res_word_o         (res_word)
  );

  // result register plus skid entry
  bpc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .push_word_i (res_word),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

>>> src/bpc_core.sv
// per-tick debounce and short/long press state update
module bpc_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  bpc_pkg::in_word_t in_word_i,
  input  logic [15:0]       debounce_ticks_i,
  input  logic [15:0]       long_press_ticks_i,
  output bpc_pkg::out_word_t res_word_o
);
  import bpc_pkg::*;

  localparam logic [32:0] CntMaxWide = (33'd1 << COUNT_WIDTH) - 33'd1;
  localparam logic [COUNT_WIDTH-1:0] CntOne = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] CntZero = '0;

  logic                   armed_level_q, armed_level_d;
  logic                   captured_level_q, captured_level_d;
  logic                   debounce_busy_q, debounce_busy_d;
  logic [COUNT_WIDTH-1:0] debounce_left_q, debounce_left_d;
  logic [COUNT_WIDTH-1:0] long_left_q, long_left_d;
  logic                   long_running_q, long_running_d;
  logic                   long_seen_q, long_seen_d;
  press_event_e           latched_event_q, latched_event_d;

  logic [COUNT_WIDTH-1:0] deb_load, long_load;
  logic                   do_settle;
  press_event_e           event_now;

  // saturate register values into the counter range
  function automatic logic [COUNT_WIDTH-1:0] clamp_count(input logic [15:0] v);
    logic [31:0] ext;
    ext = 32'(v);
    if (ext > CntMaxWide[31:0]) begin
      return CntMaxWide[COUNT_WIDTH-1:0];
    end
    return ext[COUNT_WIDTH-1:0];
  endfunction

  assign deb_load  = clamp_count(debounce_ticks_i);
  assign long_load = clamp_count(long_press_ticks_i);

  always_comb begin
    armed_level_d    = armed_level_q;
    captured_level_d = captured_level_q;
    debounce_busy_d  = debounce_busy_q;
    debounce_left_d  = debounce_left_q;
    long_left_d      = long_left_q;
    long_running_d   = long_running_q;
    long_seen_d      = long_seen_q;
    event_now        = latched_event_q;
    do_settle        = 1'b0;

    // long timer counts first
    if (long_running_q) begin
      if (long_left_q != CntZero) begin
        long_left_d = long_left_q - CntOne;
      end
      if (long_left_d == CntZero) begin
        event_now      = EvLong;
        long_seen_d    = 1'b1;
        long_running_d = 1'b0;
      end
    end

    // debounce wait and capture
    if (debounce_busy_q) begin
      if (debounce_left_q != CntZero) begin
        debounce_left_d = debounce_left_q - CntOne;
      end
      if (debounce_left_d == CntZero) begin
        do_settle = 1'b1;
      end
    end else if (in_word_i.pin_level != armed_level_q) begin
      captured_level_d = in_word_i.pin_level;
      if (deb_load == CntZero) begin
        do_settle = 1'b1;
      end else begin
        debounce_busy_d = 1'b1;
        debounce_left_d = deb_load;
      end
    end

    if (do_settle) begin
      debounce_busy_d = 1'b0;
      debounce_left_d = CntZero;
      if (in_word_i.pin_level == captured_level_d) begin
        if (!captured_level_d) begin
          long_seen_d    = 1'b0;
          long_running_d = 1'b1;
          long_left_d    = (long_load == CntZero) ? CntOne : long_load;
        end else begin
          if (!long_seen_d) begin
            event_now = EvShort;
          end
          long_running_d = 1'b0;
          long_left_d    = CntZero;
        end
      end
      armed_level_d = in_word_i.pin_level;
    end

    res_word_o.press_event        = event_now;
    res_word_o.long_timer_running = long_running_d;

    latched_event_d = in_word_i.read_clear ? EvIdle : event_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_level_q    <= 1'b1;
      captured_level_q <= 1'b0;
      debounce_busy_q  <= 1'b0;
      debounce_left_q  <= CntZero;
      long_left_q      <= CntZero;
      long_running_q   <= 1'b0;
      long_seen_q      <= 1'b0;
      latched_event_q  <= EvIdle;
    end else if (step_i) begin
      armed_level_q    <= armed_level_d;
      captured_level_q <= captured_level_d;
      debounce_busy_q  <= debounce_busy_d;
      debounce_left_q  <= debounce_left_d;
      long_left_q      <= long_left_d;
      long_running_q   <= long_running_d;
      long_seen_q      <= long_seen_d;
      latched_event_q  <= latched_event_d;
    end
  end

  a_long_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_running_q |-> long_left_q != CntZero)
    else $error("long timer running with zero count");

  a_debounce_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    debounce_busy_q |-> debounce_left_q != CntZero)
    else $error("debounce wait busy with zero count");

  a_idle_when_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(latched_event_q) && $stable(long_running_q))
    else $error("state changed without a tick");

endmodule

>>> src/bpc_out_buf.sv
// two-entry result buffer between the core and the output channel
module bpc_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bpc_pkg::out_word_t push_word_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bpc_pkg::out_word_t out_word_o
);
  import bpc_pkg::*;

  out_word_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign space_o     = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_word_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
